// ----- design/cfco_pkg.sv -----
// types and constants shared by the 3x3 convolution filter modules
// no dependencies
`timescale 1ns / 1ps

package cfco_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int COEF_ROW_W = 48;
   localparam int COEF_W     = 16;
   localparam int GEOM_W     = 11;
   localparam int PIX_W      = 24;
   localparam int ACC_W      = 28;

   localparam logic [COEF_ROW_W-1:0] COEF_TOP_RESET = 48'd0;
   localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = 48'd1024;
   localparam logic [COEF_ROW_W-1:0] COEF_BOT_RESET = 48'd0;
   localparam logic [GEOM_W-1:0]     WIDTH_RESET    = 11'd640;
   localparam logic [GEOM_W-1:0]     HEIGHT_RESET   = 11'd480;
   localparam int                    GEOM_MIN       = 3;

   localparam logic [15:0] LUMA_WB = 16'd7471;
   localparam logic [15:0] LUMA_WG = 16'd38470;
   localparam logic [15:0] LUMA_WR = 16'd19595;
   localparam int          EDGE_OFFSET = 127;
   localparam int          PIX_MAX     = 255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_TOP = 3'd0,
      REG_COEF_MID = 3'd1,
      REG_COEF_BOT = 3'd2,
      REG_WIDTH    = 3'd3,
      REG_HEIGHT   = 3'd4,
      REG_OFFSET   = 3'd5,
      REG_GRAY     = 3'd6
   } csr_reg_type;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef pix_type [2:0][2:0]       win_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic valid;
      logic border;
      logic last;
   } tag_type;

endpackage

// ----- design/cfco_ram.sv -----
// generic single write port, single read port memory with registered read
// no dependencies
`timescale 1ns / 1ps

module cfco_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cfco_cell.sv -----
// one multiply-accumulate cell of the convolution chain: adds one window
// column times its kernel column to the running sums; uses cfco_pkg
`timescale 1ns / 1ps

module cfco_cell #(
   parameter int COL = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  cfco_pkg::tag_type  tag_in,
   input  cfco_pkg::win_type  win_in,
   input  cfco_pkg::acc_type  acc_in [3],
   input  cfco_pkg::coef_type coef_in [3],
   output cfco_pkg::tag_type  tag_out,
   output cfco_pkg::win_type  win_out,
   output cfco_pkg::acc_type  acc_out [3]
);

   cfco_pkg::tag_type tag_ff;
   cfco_pkg::win_type win_ff;
   cfco_pkg::acc_type acc_ff [3];
   cfco_pkg::acc_type acc_in_sum [3];
   logic signed [cfco_pkg::COEF_W+8:0] prod;

   // coef_in is indexed by window row
   always_comb begin
      prod = '0;
      for (int ch = 0; ch < 3; ch++) begin
         acc_in_sum[ch] = acc_in[ch];
         for (int a = 0; a < 3; a++) begin
            prod = coef_in[a] * $signed({1'b0, win_in[a][COL][8*ch +: 8]});
            acc_in_sum[ch] = acc_in_sum[ch] + cfco_pkg::ACC_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         win_ff <= win_in;
         for (int ch = 0; ch < 3; ch++) begin
            acc_ff[ch] <= acc_in_sum[ch];
         end
      end
   end

   assign tag_out = tag_ff;
   assign win_out = win_ff;
   assign acc_out = acc_ff;

endmodule

// ----- design/conv3x3_filter_clamp_offset_core.sv -----
// 3x3 convolution filter core: line stores, window, mac cell chain, clamp
// depends on cfco_pkg, cfco_ram, cfco_cell
`timescale 1ns / 1ps

// Usage
//  req channel: one request per pixel in raster order (req_action 0), or a
//  drain request (req_action 1) that flushes the frame tail. Requests carry
//  B, G and R; drains before the frame is complete are dropped.
//  rsp channel: one filtered pixel per emitted position, out_last on the
//  final pixel of the frame. Output positions lag the input by W+1 pixels.
//  csr channel: always ready; writes register csr_index with csr_data.
// Timing
//  one request per cycle sustained when nothing stalls. A result passes
//  the request stage, the window stage, three mac cells, then the clamp
//  into the output register. After every csr write req_ready stays low
//  while a shift-subtract divider rebuilds the output column and row
//  from the linear output index.
// Reset clears the counters, the window and all valid flags; the line
// stores are not cleared. While a result waits in the output register
// and rsp_ready is low the whole pipeline holds and req_ready drops.
module conv3x3_filter_clamp_offset_core #(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_HEIGHT     = 1024,
   parameter int COEF_FRAC_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [7:0]                         req_in_blue,
   input  logic [7:0]                         req_in_green,
   input  logic [7:0]                         req_in_red,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_blue,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_red,
   output logic                               rsp_out_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfco_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cfco_pkg::COEF_ROW_W-1:0]    csr_data
);

   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int ROW_W  = IDX_W + 1;
   localparam int IW     = WW + HW + 1;
   localparam int DCW    = $clog2(IDX_W + 2);
   localparam logic signed [cfco_pkg::ACC_W-1:0] EdgeOff =
      cfco_pkg::ACC_W'(cfco_pkg::EDGE_OFFSET * (1 << COEF_FRAC_BITS));
   localparam logic signed [cfco_pkg::ACC_W-1:0] PixMaxS =
      cfco_pkg::ACC_W'(cfco_pkg::PIX_MAX);

   // configuration
   logic [cfco_pkg::COEF_ROW_W-1:0] coef_row_ff [3];
   logic [cfco_pkg::GEOM_W-1:0]     width_ff;
   logic [cfco_pkg::GEOM_W-1:0]     height_ff;
   logic                            offset_ff;
   logic                            gray_ff;
   logic                            csr_accept;

   logic [WW-1:0]    w;
   logic [HW-1:0]    h;
   logic [TOT_W-1:0] total_ff;

   // position counters
   logic [WW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic [WW-1:0]    ox_ff, ox_in;
   logic [IDX_W-1:0] oy_ff, oy_in;

   // divider rebuilding ox/oy
   logic [DCW-1:0]   div_cnt_ff, div_cnt_in;
   logic [WW-1:0]    rem_ff;
   logic [IDX_W-1:0] quo_ff;
   logic [WW:0]      rem_sh;
   logic             rem_ge;
   logic [WW-1:0]    rem_n;
   logic [IDX_W-1:0] quo_n;

   // request decode
   logic          adv;
   logic          req_accept;
   logic          full;
   logic          do_shift;
   logic          emit;
   logic          is_last;
   logic          is_border;
   logic [IW-1:0] idx;

   // request stage
   logic          a_valid_ff;
   logic          a_emit_ff;
   logic          a_border_ff;
   logic          a_last_ff;
   logic [AW-1:0] a_col_ff;
   logic [23:0]   a_bgr_ff;

   // window stage
   cfco_pkg::win_type win_ff;
   cfco_pkg::tag_type b_tag_ff;
   cfco_pkg::pix_type upper_rd, lower_rd, new_pix;
   logic [24:0]       luma_sum;
   logic [7:0]        luma;

   // cell chain
   cfco_pkg::tag_type  c_tag [4];
   cfco_pkg::win_type  c_win [4];
   cfco_pkg::acc_type  c_acc [4][3];
   cfco_pkg::coef_type cell_coef [3][3];

   // clamp and output
   cfco_pkg::acc_type ch_sum [3];
   cfco_pkg::acc_type ch_shift [3];
   logic [7:0]        ch_res [3];
   logic              rsp_valid_ff;
   logic [7:0]        out_b_ff, out_g_ff, out_r_ff;
   logic              out_last_ff;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_row_ff[0] <= cfco_pkg::COEF_TOP_RESET;
         coef_row_ff[1] <= cfco_pkg::COEF_MID_RESET;
         coef_row_ff[2] <= cfco_pkg::COEF_BOT_RESET;
         width_ff       <= cfco_pkg::WIDTH_RESET;
         height_ff      <= cfco_pkg::HEIGHT_RESET;
         offset_ff      <= 1'b0;
         gray_ff        <= 1'b0;
      end else if (csr_accept) begin
         unique case (csr_index)
            cfco_pkg::REG_COEF_TOP: coef_row_ff[0] <= csr_data;
            cfco_pkg::REG_COEF_MID: coef_row_ff[1] <= csr_data;
            cfco_pkg::REG_COEF_BOT: coef_row_ff[2] <= csr_data;
            cfco_pkg::REG_WIDTH:    width_ff  <= csr_data[cfco_pkg::GEOM_W-1:0];
            cfco_pkg::REG_HEIGHT:   height_ff <= csr_data[cfco_pkg::GEOM_W-1:0];
            cfco_pkg::REG_OFFSET:   offset_ff <= csr_data[0];
            cfco_pkg::REG_GRAY:     gray_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // geometry limited to 3..max
   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else if (32'(width_ff) < cfco_pkg::GEOM_MIN) begin
         w = WW'(cfco_pkg::GEOM_MIN);
      end else begin
         w = WW'(width_ff);
      end
      if (32'(height_ff) > MAX_HEIGHT) begin
         h = HW'(MAX_HEIGHT);
      end else if (32'(height_ff) < cfco_pkg::GEOM_MIN) begin
         h = HW'(cfco_pkg::GEOM_MIN);
      end else begin
         h = HW'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= TOT_W'(w * h);
   end

   // pipeline moves whenever the output register can take a result
   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = adv && (div_cnt_ff == '0);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      full      = row_ff >= ROW_W'(h);
      idx       = IW'(row_ff[HW-1:0] * w) + IW'(col_ff);
      do_shift  = req_accept && (!req_action || full);
      emit      = do_shift && (full || idx >= IW'(w) + IW'(1));
      is_last   = TOT_W'(oidx_ff) + TOT_W'(1) >= total_ff;
      is_border = (ox_ff == '0) || (ox_ff == w - WW'(1)) || (oy_ff == '0) ||
                  ((IDX_W + 1)'(oy_ff) >= (IDX_W + 1)'(h) - (IDX_W + 1)'(1));
   end

   // shift-subtract step: out_index / w
   always_comb begin
      rem_sh = {rem_ff, quo_ff[IDX_W-1]};
      rem_ge = rem_sh >= {1'b0, w};
      rem_n  = rem_ge ? WW'(rem_sh - {1'b0, w}) : WW'(rem_sh);
      quo_n  = {quo_ff[IDX_W-2:0], rem_ge};
   end

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      oidx_in    = oidx_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      div_cnt_in = div_cnt_ff;
      if (do_shift) begin
         if (col_ff + WW'(1) >= w) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + WW'(1);
         end
      end
      if (emit) begin
         if (is_last) begin
            col_in  = '0;
            row_in  = '0;
            oidx_in = '0;
            ox_in   = '0;
            oy_in   = '0;
         end else begin
            oidx_in = oidx_ff + IDX_W'(1);
            if (ox_ff == w - WW'(1)) begin
               ox_in = '0;
               oy_in = oy_ff + IDX_W'(1);
            end else begin
               ox_in = ox_ff + WW'(1);
            end
         end
      end
      if (csr_accept) begin
         div_cnt_in = DCW'(IDX_W + 1);
      end else if (div_cnt_ff != '0) begin
         div_cnt_in = div_cnt_ff - DCW'(1);
      end
      if (div_cnt_ff == DCW'(1)) begin
         ox_in = rem_n;
         oy_in = quo_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         oidx_ff    <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         div_cnt_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         oidx_ff    <= oidx_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_cnt_ff == DCW'(IDX_W + 1)) begin
         rem_ff <= '0;
         quo_ff <= oidx_ff;
      end else if (div_cnt_ff != '0) begin
         rem_ff <= rem_n;
         quo_ff <= quo_n;
      end
   end

   // request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= do_shift;
      end
   end

   // a pixel request after the frame is complete acts as a drain
   always_ff @(posedge clock) begin
      if (do_shift) begin
         a_emit_ff   <= emit;
         a_border_ff <= is_border;
         a_last_ff   <= is_last;
         a_col_ff    <= col_ff[AW-1:0];
         a_bgr_ff    <= (req_action || full) ? 24'd0 :
                        {req_in_red, req_in_green, req_in_blue};
      end
   end

   cfco_ram #(.WIDTH(cfco_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (adv && a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data (lower_rd),
      .rd_en   (do_shift),
      .rd_addr (col_ff[AW-1:0]),
      .rd_data (upper_rd)
   );

   cfco_ram #(.WIDTH(cfco_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   (adv && a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data (new_pix),
      .rd_en   (do_shift),
      .rd_addr (col_ff[AW-1:0]),
      .rd_data (lower_rd)
   );

   // luma with 16-bit fractional weights, floored
   always_comb begin
      luma_sum = 25'(cfco_pkg::LUMA_WB) * 25'(a_bgr_ff[7:0]) +
                 25'(cfco_pkg::LUMA_WG) * 25'(a_bgr_ff[15:8]) +
                 25'(cfco_pkg::LUMA_WR) * 25'(a_bgr_ff[23:16]);
      luma     = luma_sum[23:16];
      new_pix  = gray_ff ? {luma, luma, luma} : a_bgr_ff;
   end

   // window stage
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         b_tag_ff <= '0;
      end else if (adv) begin
         b_tag_ff.valid  <= a_valid_ff && a_emit_ff;
         b_tag_ff.border <= a_border_ff;
         b_tag_ff.last   <= a_last_ff;
         if (a_valid_ff) begin
            for (int a = 0; a < 3; a++) begin
               win_ff[a][0] <= win_ff[a][1];
               win_ff[a][1] <= win_ff[a][2];
            end
            win_ff[0][2] <= upper_rd;
            win_ff[1][2] <= lower_rd;
            win_ff[2][2] <= new_pix;
         end
      end
   end

   // cell k takes window column k against kernel column 2-k, row flipped
   assign c_tag[0] = b_tag_ff;
   assign c_win[0] = win_ff;
   assign c_acc[0] = '{default: '0};

   for (genvar k = 0; k < 3; k++) begin : g_cell
      for (genvar a = 0; a < 3; a++) begin : g_coef
         assign cell_coef[k][a] = coef_row_ff[2-a][16*(2-k) +: 16];
      end
      cfco_cell #(.COL(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (adv),
         .tag_in  (c_tag[k]),
         .win_in  (c_win[k]),
         .acc_in  (c_acc[k]),
         .coef_in (cell_coef[k]),
         .tag_out (c_tag[k+1]),
         .win_out (c_win[k+1]),
         .acc_out (c_acc[k+1])
      );
   end

   // offset, clamp and floor, or center pixel at the border
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ch_sum[ch]   = c_acc[3][ch] + (offset_ff ? EdgeOff : '0);
         ch_shift[ch] = ch_sum[ch] >>> COEF_FRAC_BITS;
         if (c_tag[3].border) begin
            ch_res[ch] = c_win[3][1][1][8*ch +: 8];
         end else if (ch_sum[ch][cfco_pkg::ACC_W-1]) begin
            ch_res[ch] = 8'd0;
         end else if (ch_shift[ch] > PixMaxS) begin
            ch_res[ch] = 8'(cfco_pkg::PIX_MAX);
         end else begin
            ch_res[ch] = ch_shift[ch][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_tag[3].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_b_ff    <= ch_res[0];
         out_g_ff    <= ch_res[1];
         out_r_ff    <= ch_res[2];
         out_last_ff <= c_tag[3].last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_last  = out_last_ff;

endmodule

// ----- design/cfco_checker.sv -----
// port-level checks for the 3x3 convolution filter core, bound to the top
// depends on conv3x3_filter_clamp_offset_core port list and cfco_pkg
`timescale 1ns / 1ps

module cfco_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_action,
   input logic [7:0]                      req_in_blue,
   input logic [7:0]                      req_in_green,
   input logic [7:0]                      req_in_red,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_out_blue,
   input logic [7:0]                      rsp_out_green,
   input logic [7:0]                      rsp_out_red,
   input logic                            rsp_out_last,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [cfco_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [cfco_pkg::COEF_ROW_W-1:0] csr_data
);

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_blue) &&
      $stable(rsp_out_green) && $stable(rsp_out_red) && $stable(rsp_out_last))
      else $error("stalled result changed");

   // a register write blocks requests while positions are rebuilt
   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request taken right after register write");

   // a full output register with a stalled receiver blocks requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

endmodule

bind conv3x3_filter_clamp_offset_core cfco_checker u_cfco_checker (.*);
